[rtl/teu_pkg.sv]
// ----------------------------------------------------------------------------
// teu_pkg
// Shared types and constants of the timestamp epoch unwrapper.
// ----------------------------------------------------------------------------
`default_nettype none

package teu_pkg;

   // number of counter wraps tried per data request
   localparam int EPOCH_COUNT = 100;
   localparam int EPOCH_W     = 7;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST = EPOCH_W'(EPOCH_COUNT - 1);

   localparam int TIME_W   = 48;
   localparam int MOD_W    = 36;
   localparam int UNWRAP_W = 49;
   localparam int FINE_W   = 54;
   localparam int POS_W    = 32;
   localparam int FTOA_W   = 4;
   // anchor is compared at sixteen times its value (12288 / 768)
   localparam int DIST_W   = TIME_W + 4;

   // request kinds
   localparam logic [1:0] CMD_GLOBAL  = 2'd0;
   localparam logic [1:0] CMD_PIXEL   = 2'd1;
   localparam logic [1:0] CMD_TDC     = 2'd2;
   localparam logic [1:0] CMD_CONTROL = 2'd3;

   // result status codes
   localparam logic [1:0] ST_PASS     = 2'd0;
   localparam logic [1:0] ST_ANCHOR   = 2'd1;
   localparam logic [1:0] ST_UNWRAP   = 2'd2;
   localparam logic [1:0] ST_NOANCHOR = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_CHIP_SELECT     = 2'd0;
   localparam logic [1:0] REG_PIXEL_MODULUS   = 2'd1;
   localparam logic [1:0] REG_TDC_MODULUS     = 2'd2;
   localparam logic [1:0] REG_CONTROL_MODULUS = 2'd3;

   localparam logic [MOD_W-1:0] PIXEL_MOD_RESET   = MOD_W'(36'd16384);
   localparam logic [MOD_W-1:0] TDC_MOD_RESET     = MOD_W'(36'd34359738368);
   localparam logic [MOD_W-1:0] CONTROL_MOD_RESET = MOD_W'(36'd4294967296);

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic step;
      logic load_out;
   } teu_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_search;
      logic last_epoch;
   } teu_stat_type;

endpackage

`default_nettype wire

[rtl/teu_ctrl.sv]
// ----------------------------------------------------------------------------
// teu_ctrl
// Sequencer: accept a request, run the epoch search, hand off the response.
// ----------------------------------------------------------------------------
`default_nettype none

module teu_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire teu_pkg::teu_stat_type stat,
   output teu_pkg::teu_cmd_type       cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_DONE   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.accept   = 1'b0;
      cmd.step     = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.needs_search ? S_SEARCH : S_DONE;
            end
         end
         S_SEARCH: begin
            cmd.step = 1'b1;
            if (stat.last_epoch) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for the response register to drain
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_search_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && stat.last_epoch) |=> (state_ff == S_DONE))
      else $error("search did not finish after the last epoch");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("response loaded but not presented");

   a_done_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (state_ff == S_IDLE))
      else $error("finished request not handed off");

endmodule

`default_nettype wire

[rtl/teu_dpath.sv]
// ----------------------------------------------------------------------------
// teu_dpath
// Registers, anchor tracking and the one-epoch-per-cycle distance compare.
// ----------------------------------------------------------------------------
`default_nettype none

module teu_dpath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_en,
   input  wire logic [1:0]                           csr_index,
   input  wire logic [teu_pkg::MOD_W-1:0]            csr_wdata,
   input  wire logic [1:0]                           req_command,
   input  wire logic [1:0]                           req_chip,
   input  wire logic [teu_pkg::TIME_W-1:0]           req_time_value,
   input  wire logic [teu_pkg::FTOA_W-1:0]           req_fine_toa,
   input  wire logic                                 req_is_packet_count,
   input  wire logic [teu_pkg::POS_W-1:0]            req_chunk_number,
   input  wire logic [teu_pkg::POS_W-1:0]            req_packet_number,
   input  wire teu_pkg::teu_cmd_type                 cmd,
   output teu_pkg::teu_stat_type                     stat,
   output logic [1:0]                                rsp_status,
   output logic [teu_pkg::EPOCH_W-1:0]               rsp_epoch,
   output logic [teu_pkg::UNWRAP_W-1:0]              rsp_unwrapped_time,
   output logic signed [teu_pkg::FINE_W-1:0]         rsp_fine_time
);

   // configuration
   logic [1:0]                  chip_select_ff, chip_select_in;
   logic [teu_pkg::MOD_W-1:0]   pixel_mod_ff, pixel_mod_in;
   logic [teu_pkg::MOD_W-1:0]   tdc_mod_ff, tdc_mod_in;
   logic [teu_pkg::MOD_W-1:0]   control_mod_ff, control_mod_in;

   // anchor
   logic                        anchor_valid_ff, anchor_valid_in;
   logic [teu_pkg::TIME_W-1:0]  anchor_time_ff, anchor_time_in;
   logic [teu_pkg::POS_W-1:0]   anchor_chunk_ff, anchor_chunk_in;
   logic [teu_pkg::POS_W-1:0]   anchor_packet_ff, anchor_packet_in;

   // current request and search
   logic [1:0]                  item_status_ff, item_status_in;
   logic                        item_pixel_ff, item_pixel_in;
   logic [teu_pkg::FTOA_W-1:0]  item_ftoa_ff, item_ftoa_in;
   logic [teu_pkg::MOD_W-1:0]   mod_ff, mod_in;
   logic [teu_pkg::UNWRAP_W-1:0] acc_ff, acc_in;
   logic [teu_pkg::EPOCH_W-1:0] ep_ff, ep_in;
   logic [teu_pkg::EPOCH_W-1:0] best_ep_ff, best_ep_in;
   logic [teu_pkg::UNWRAP_W-1:0] best_x_ff, best_x_in;
   logic [teu_pkg::DIST_W-1:0]  best_dist_ff, best_dist_in;

   // request classification
   logic                        selected, is_global, is_data, earlier;
   logic [1:0]                  req_status;
   logic [teu_pkg::MOD_W-1:0]   req_mod;

   // distance
   logic [teu_pkg::DIST_W-1:0]  target, cand, span;
   logic                        better;
   logic [teu_pkg::FINE_W-1:0]  fine_calc;

   assign selected  = (req_chip == chip_select_ff);
   assign is_global = (req_command == teu_pkg::CMD_GLOBAL);
   assign is_data   = selected && !is_global &&
                      !((req_command == teu_pkg::CMD_CONTROL) && req_is_packet_count);
   assign earlier   = !anchor_valid_ff || (req_chunk_number < anchor_chunk_ff) ||
                      ((req_chunk_number == anchor_chunk_ff) &&
                       (req_packet_number < anchor_packet_ff));

   always_comb begin
      if (selected && is_global) begin
         req_status = teu_pkg::ST_ANCHOR;
      end else if (is_data) begin
         req_status = anchor_valid_ff ? teu_pkg::ST_UNWRAP : teu_pkg::ST_NOANCHOR;
      end else begin
         req_status = teu_pkg::ST_PASS;
      end
   end

   always_comb begin
      unique case (req_command)
         teu_pkg::CMD_PIXEL:   req_mod = pixel_mod_ff;
         teu_pkg::CMD_TDC:     req_mod = tdc_mod_ff;
         teu_pkg::CMD_CONTROL: req_mod = control_mod_ff;
         default:              req_mod = control_mod_ff;
      endcase
   end

   assign stat.needs_search = is_data && anchor_valid_ff;
   assign stat.last_epoch   = (ep_ff == teu_pkg::EPOCH_LAST);

   // compare at scale 1/768: candidate x against anchor * 16
   assign target = {anchor_time_ff, 4'b0000};
   assign cand   = teu_pkg::DIST_W'(acc_ff);
   assign span   = (cand >= target) ? (cand - target) : (target - cand);
   assign better = (ep_ff == '0) || (span < best_dist_ff);

   assign fine_calc = {1'b0, best_x_ff, 4'b0000} - teu_pkg::FINE_W'(item_ftoa_ff);

   always_comb begin
      chip_select_in = chip_select_ff;
      pixel_mod_in   = pixel_mod_ff;
      tdc_mod_in     = tdc_mod_ff;
      control_mod_in = control_mod_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            teu_pkg::REG_CHIP_SELECT:     chip_select_in = csr_wdata[1:0];
            teu_pkg::REG_PIXEL_MODULUS:   pixel_mod_in   = csr_wdata;
            teu_pkg::REG_TDC_MODULUS:     tdc_mod_in     = csr_wdata;
            teu_pkg::REG_CONTROL_MODULUS: control_mod_in = csr_wdata;
            default:                      chip_select_in = chip_select_ff;
         endcase
      end
   end

   always_comb begin
      anchor_valid_in  = anchor_valid_ff;
      anchor_time_in   = anchor_time_ff;
      anchor_chunk_in  = anchor_chunk_ff;
      anchor_packet_in = anchor_packet_ff;
      item_status_in   = item_status_ff;
      item_pixel_in    = item_pixel_ff;
      item_ftoa_in     = item_ftoa_ff;
      mod_in           = mod_ff;
      acc_in           = acc_ff;
      ep_in            = ep_ff;
      best_ep_in       = best_ep_ff;
      best_x_in        = best_x_ff;
      best_dist_in     = best_dist_ff;
      if (cmd.accept) begin
         // keep the earliest-positioned anchor; ties keep the first arrival
         if (selected && is_global && earlier) begin
            anchor_valid_in  = 1'b1;
            anchor_time_in   = req_time_value;
            anchor_chunk_in  = req_chunk_number;
            anchor_packet_in = req_packet_number;
         end
         item_status_in = req_status;
         item_pixel_in  = is_data && (req_command == teu_pkg::CMD_PIXEL);
         item_ftoa_in   = req_fine_toa;
         mod_in         = req_mod;
         acc_in         = teu_pkg::UNWRAP_W'(req_time_value);
         ep_in          = '0;
         best_ep_in     = '0;
         best_x_in      = teu_pkg::UNWRAP_W'(req_time_value);
      end else if (cmd.step) begin
         if (better) begin
            best_ep_in   = ep_ff;
            best_x_in    = acc_ff;
            best_dist_in = span;
         end
         acc_in = acc_ff + teu_pkg::UNWRAP_W'(mod_ff);
         ep_in  = ep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_select_ff   <= '0;
         pixel_mod_ff     <= teu_pkg::PIXEL_MOD_RESET;
         tdc_mod_ff       <= teu_pkg::TDC_MOD_RESET;
         control_mod_ff   <= teu_pkg::CONTROL_MOD_RESET;
         anchor_valid_ff  <= 1'b0;
         anchor_time_ff   <= '0;
         anchor_chunk_ff  <= '0;
         anchor_packet_ff <= '0;
      end else begin
         chip_select_ff   <= chip_select_in;
         pixel_mod_ff     <= pixel_mod_in;
         tdc_mod_ff       <= tdc_mod_in;
         control_mod_ff   <= control_mod_in;
         anchor_valid_ff  <= anchor_valid_in;
         anchor_time_ff   <= anchor_time_in;
         anchor_chunk_ff  <= anchor_chunk_in;
         anchor_packet_ff <= anchor_packet_in;
      end
   end

   always_ff @(posedge clock) begin
      item_status_ff <= item_status_in;
      item_pixel_ff  <= item_pixel_in;
      item_ftoa_ff   <= item_ftoa_in;
      mod_ff         <= mod_in;
      acc_ff         <= acc_in;
      ep_ff          <= ep_in;
      best_ep_ff     <= best_ep_in;
      best_x_ff      <= best_x_in;
      best_dist_ff   <= best_dist_in;
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status         <= item_status_ff;
         rsp_epoch          <= best_ep_ff;
         rsp_unwrapped_time <= best_x_ff;
         rsp_fine_time      <= item_pixel_ff ? $signed(fine_calc) : '0;
      end
   end

   a_epoch_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (ep_ff <= teu_pkg::EPOCH_LAST))
      else $error("epoch counter ran past the last epoch");

endmodule

`default_nettype wire

[rtl/timestamp_epoch_unwrapper_core.sv]
// A global, passed or anchorless request goes from acceptance straight to the response register,
// while an unwrapped data request first runs 100 epoch compares, one per cycle.
// A new request is taken only after the previous one is loaded into the response register,
// since the single shared epoch accumulator and distance comparator serve one at a time.
// Reset (synchronous, active high): registers to defaults, no anchor held, no response pending.
// ----------------------------------------------------------------------------
// timestamp_epoch_unwrapper_core
// Unwraps wrapped hit timestamps of the selected chip against the earliest
// global-time anchor seen, by searching the counter epoch closest to it.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_epoch_unwrapper_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration writes
   input  wire logic                              csr_write_en,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [teu_pkg::MOD_W-1:0]         csr_wdata,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_command,
   input  wire logic [1:0]                        req_chip,
   input  wire logic [teu_pkg::TIME_W-1:0]        req_time_value,
   input  wire logic [teu_pkg::FTOA_W-1:0]        req_fine_toa,
   input  wire logic                              req_is_packet_count,
   input  wire logic [teu_pkg::POS_W-1:0]         req_chunk_number,
   input  wire logic [teu_pkg::POS_W-1:0]         req_packet_number,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [1:0]                             rsp_status,
   output logic [teu_pkg::EPOCH_W-1:0]            rsp_epoch,
   output logic [teu_pkg::UNWRAP_W-1:0]           rsp_unwrapped_time,
   output logic signed [teu_pkg::FINE_W-1:0]      rsp_fine_time
);

   // Controller and datapath talk only through these two bundles: the
   // controller says accept / step / load, the datapath answers whether the
   // request needs a search and whether the last epoch is under compare.
   teu_pkg::teu_cmd_type  cmd;
   teu_pkg::teu_stat_type stat;

   // Sequencer: IDLE takes a request, SEARCH walks epochs 0..99, DONE waits
   // for the response register to be free and loads it. The response register
   // separates the two sides, so a new request is taken while the previous
   // response still waits downstream.
   teu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: the candidate raw + e*modulus advances by one modulus per
   // cycle (no multiplier). Both sides of the compare carry the common factor
   // 768, so the distance is taken against anchor*16; strict less-than keeps
   // the lowest epoch on ties.
   teu_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_command         (req_command),
      .req_chip            (req_chip),
      .req_time_value      (req_time_value),
      .req_fine_toa        (req_fine_toa),
      .req_is_packet_count (req_is_packet_count),
      .req_chunk_number    (req_chunk_number),
      .req_packet_number   (req_packet_number),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_status          (rsp_status),
      .rsp_epoch           (rsp_epoch),
      .rsp_unwrapped_time  (rsp_unwrapped_time),
      .rsp_fine_time       (rsp_fine_time)
   );

endmodule

`default_nettype wire

[dv/tb_timestamp_epoch_unwrapper_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamp_epoch_unwrapper_core
// Self-checking bench for the epoch unwrapper core. It sends directed and
// random hit and global-time requests under random valid/ready gaps, predicts
// every response with a local model of the anchor and the epoch search, and
// compares each response field by field.
// ----------------------------------------------------------------------------

module tb_timestamp_epoch_unwrapper_core;

   typedef struct packed {
      logic [1:0]                 command;
      logic [1:0]                 chip;
      logic [teu_pkg::TIME_W-1:0] time_value;
      logic [teu_pkg::FTOA_W-1:0] fine_toa;
      logic                       is_packet_count;
      logic [teu_pkg::POS_W-1:0]  chunk_number;
      logic [teu_pkg::POS_W-1:0]  packet_number;
   } hit_req_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic [teu_pkg::EPOCH_W-1:0]  epoch;
      logic [teu_pkg::UNWRAP_W-1:0] unwrapped_time;
      logic [teu_pkg::FINE_W-1:0]   fine_time;
   } hit_rsp_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_write_en;
   logic [1:0]                        csr_index;
   logic [teu_pkg::MOD_W-1:0]         csr_wdata;
   logic                              req_valid;
   logic                              req_ready;
   logic [1:0]                        req_command;
   logic [1:0]                        req_chip;
   logic [teu_pkg::TIME_W-1:0]        req_time_value;
   logic [teu_pkg::FTOA_W-1:0]        req_fine_toa;
   logic                              req_is_packet_count;
   logic [teu_pkg::POS_W-1:0]         req_chunk_number;
   logic [teu_pkg::POS_W-1:0]         req_packet_number;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [1:0]                        rsp_status;
   logic [teu_pkg::EPOCH_W-1:0]       rsp_epoch;
   logic [teu_pkg::UNWRAP_W-1:0]      rsp_unwrapped_time;
   logic signed [teu_pkg::FINE_W-1:0] rsp_fine_time;

   // local copy of the configuration registers
   logic [1:0]                sel_chip;
   logic [teu_pkg::MOD_W-1:0] mod_pixel;
   logic [teu_pkg::MOD_W-1:0] mod_tdc;
   logic [teu_pkg::MOD_W-1:0] mod_control;

   // local copy of the kept anchor
   logic                       anc_valid;
   logic [teu_pkg::TIME_W-1:0] anc_time;
   logic [teu_pkg::POS_W-1:0]  anc_chunk;
   logic [teu_pkg::POS_W-1:0]  anc_packet;

   hit_rsp_type pending_rsp[$];

   int  error_count   = 0;
   int  sent_count    = 0;
   int  checked_count = 0;
   int  searched_count = 0;
   int  anchor_moves  = 0;
   bit  steady_flow   = 1'b0;  // no gaps on either side while set
   bit  hold_request  = 1'b0;  // ask the receiver for one long hold-off
   int  hold_left     = 0;
   int  stall_left    = 0;

   timestamp_epoch_unwrapper_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_chip            (req_chip),
      .req_time_value      (req_time_value),
      .req_fine_toa        (req_fine_toa),
      .req_is_packet_count (req_is_packet_count),
      .req_chunk_number    (req_chunk_number),
      .req_packet_number   (req_packet_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_epoch           (rsp_epoch),
      .rsp_unwrapped_time  (rsp_unwrapped_time),
      .rsp_fine_time       (rsp_fine_time)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the core hangs.
   initial begin
      #2_000_000;
      $display("tb_timestamp_epoch_unwrapper_core: errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Compute the response of one accepted request and advance the anchor.
   function automatic hit_rsp_type predict_unwrap(input hit_req_type r);
      hit_rsp_type o;
      logic [63:0] modulus;
      logic [63:0] target;
      logic [63:0] cand;
      logic [63:0] span_now;
      logic [63:0] best_span;
      logic [63:0] unwrapped;
      int          best;
      int          ep;
      o.status         = teu_pkg::ST_PASS;
      o.epoch          = '0;
      o.unwrapped_time = {1'b0, r.time_value};
      o.fine_time      = '0;
      if (r.chip == sel_chip) begin
         if (r.command == teu_pkg::CMD_GLOBAL) begin
            // keep the earliest (chunk, packet) position; a tie keeps the old one
            if (!anc_valid || r.chunk_number < anc_chunk ||
                (r.chunk_number == anc_chunk && r.packet_number < anc_packet)) begin
               anc_valid  = 1'b1;
               anc_time   = r.time_value;
               anc_chunk  = r.chunk_number;
               anc_packet = r.packet_number;
               anchor_moves++;
            end
            o.status = teu_pkg::ST_ANCHOR;
         end else if (!(r.command == teu_pkg::CMD_CONTROL && r.is_packet_count)) begin
            case (r.command)
               teu_pkg::CMD_PIXEL: modulus = 64'(mod_pixel);
               teu_pkg::CMD_TDC:   modulus = 64'(mod_tdc);
               default:            modulus = 64'(mod_control);
            endcase
            best = 0;
            if (anc_valid) begin
               // both sides scaled to a common unit; lowest epoch wins on a tie
               target    = 64'(anc_time) * 64'd12288;
               best_span = '1;
               for (ep = 0; ep < teu_pkg::EPOCH_COUNT; ep++) begin
                  cand     = (64'(r.time_value) + 64'(ep) * modulus) * 64'd768;
                  span_now = cand > target ? cand - target : target - cand;
                  if (span_now < best_span) begin
                     best_span = span_now;
                     best      = ep;
                  end
               end
               o.status = teu_pkg::ST_UNWRAP;
               searched_count++;
            end else begin
               o.status = teu_pkg::ST_NOANCHOR;
            end
            unwrapped        = 64'(r.time_value) + 64'(best) * modulus;
            o.epoch          = teu_pkg::EPOCH_W'(best);
            o.unwrapped_time = unwrapped[teu_pkg::UNWRAP_W-1:0];
            if (r.command == teu_pkg::CMD_PIXEL)
               o.fine_time = teu_pkg::FINE_W'((unwrapped << 4) - 64'(r.fine_toa));
         end
      end
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_flow) return 0;
      if (roll < 45) return 0;
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   // Random time of random width, so small and full-range values both show up.
   function automatic logic [teu_pkg::TIME_W-1:0] random_time();
      int w;
      w = $urandom_range(1, teu_pkg::TIME_W);
      return teu_pkg::TIME_W'({$urandom, $urandom} & ((64'd1 << w) - 64'd1));
   endfunction

   function automatic logic [teu_pkg::MOD_W-1:0] random_modulus(input int max_w);
      int          w;
      logic [63:0] m;
      w = $urandom_range(1, max_w);
      m = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
      return (m == '0) ? teu_pkg::MOD_W'(1) : teu_pkg::MOD_W'(m);
   endfunction

   // Raw counter aimed at some epoch around the kept anchor, within half a
   // period either way; now and then exactly halfway so two epochs tie.
   function automatic logic [teu_pkg::TIME_W-1:0] near_anchor_raw(
         input logic [teu_pkg::MOD_W-1:0] modulus);
      logic [63:0] target;
      logic [63:0] top_epoch;
      logic [63:0] raw;
      int          ep;
      target = {12'd0, anc_time, 4'd0};
      if (modulus == '0) return random_time();
      top_epoch = target / 64'(modulus);
      if (top_epoch > 64'(teu_pkg::EPOCH_COUNT - 1))
         top_epoch = 64'(teu_pkg::EPOCH_COUNT - 1);
      ep  = $urandom_range(0, int'(top_epoch));
      raw = target - 64'(ep) * 64'(modulus);
      if ($urandom_range(0, 7) == 0)
         raw = raw - 64'(modulus >> 1);
      else
         raw = raw + ({$urandom, $urandom} % (64'(modulus) + 64'd1)) - 64'(modulus >> 1);
      if (raw[63:teu_pkg::TIME_W] != '0) return random_time();
      return raw[teu_pkg::TIME_W-1:0];
   endfunction

   function automatic hit_req_type build_request(input logic [1:0] command,
                                                 input logic [1:0] chip,
                                                 input logic [teu_pkg::TIME_W-1:0] tv,
                                                 input logic [teu_pkg::FTOA_W-1:0] ftoa,
                                                 input logic pc,
                                                 input logic [teu_pkg::POS_W-1:0] chunk,
                                                 input logic [teu_pkg::POS_W-1:0] packet);
      hit_req_type r;
      r.command         = command;
      r.chip            = chip;
      r.time_value      = tv;
      r.fine_toa        = ftoa;
      r.is_packet_count = pc;
      r.chunk_number    = chunk;
      r.packet_number   = packet;
      return r;
   endfunction

   // Mostly selected-chip traffic; globals mostly land right around the kept
   // anchor position so the earliest-position rule gets real work.
   function automatic hit_req_type random_request();
      hit_req_type               r;
      int                        pick;
      logic [teu_pkg::MOD_W-1:0] modulus;
      pick = $urandom_range(0, 99);
      r.command = pick < 15 ? teu_pkg::CMD_GLOBAL : pick < 50 ? teu_pkg::CMD_PIXEL :
                  pick < 70 ? teu_pkg::CMD_TDC : teu_pkg::CMD_CONTROL;
      r.chip = ($urandom_range(0, 4) == 0) ? 2'($urandom) : sel_chip;
      r.fine_toa = teu_pkg::FTOA_W'($urandom);
      r.is_packet_count = (r.command == teu_pkg::CMD_CONTROL) ? ($urandom_range(0, 4) == 0)
                                                               : 1'($urandom);
      r.chunk_number  = $urandom;
      r.packet_number = $urandom;
      case (r.command)
         teu_pkg::CMD_PIXEL: modulus = mod_pixel;
         teu_pkg::CMD_TDC:   modulus = mod_tdc;
         default:            modulus = mod_control;
      endcase
      if (r.command == teu_pkg::CMD_GLOBAL) begin
         r.time_value = random_time();
         if ($urandom_range(0, 9) != 0) begin
            r.chunk_number  = anc_chunk + teu_pkg::POS_W'($urandom_range(0, 2))
                              - teu_pkg::POS_W'(1);
            r.packet_number = anc_packet + teu_pkg::POS_W'($urandom_range(0, 4))
                              - teu_pkg::POS_W'(2);
         end
      end else if (anc_valid && $urandom_range(0, 9) < 7) begin
         r.time_value = near_anchor_raw(modulus);
      end else begin
         r.time_value = random_time();
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   // Offer one request after a random gap and hold it until accepted.
   // Called and returns at a falling edge; valid stays high on return.
   task automatic send_request(input hit_req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command         = r.command;
      req_chip            = r.chip;
      req_time_value      = r.time_value;
      req_fine_toa        = r.fine_toa;
      req_is_packet_count = r.is_packet_count;
      req_chunk_number    = r.chunk_number;
      req_packet_number   = r.packet_number;
      req_valid           = 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_rsp.insert(pending_rsp.size(), predict_unwrap(r));
      sent_count++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted response has come back.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Register writes happen only with the core idle.
   task automatic write_reg(input logic [1:0] index,
                            input logic [teu_pkg::MOD_W-1:0] value);
      wait_drained();
      csr_write_en = 1'b1;
      csr_index    = index;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (index)
         teu_pkg::REG_CHIP_SELECT:     sel_chip    = value[1:0];
         teu_pkg::REG_PIXEL_MODULUS:   mod_pixel   = value;
         teu_pkg::REG_TDC_MODULUS:     mod_tdc     = value;
         teu_pkg::REG_CONTROL_MODULUS: mod_control = value;
      endcase
   endtask

   task automatic apply_settings(input logic [1:0] chip,
                                 input logic [teu_pkg::MOD_W-1:0] pm,
                                 input logic [teu_pkg::MOD_W-1:0] tm,
                                 input logic [teu_pkg::MOD_W-1:0] cm);
      write_reg(teu_pkg::REG_CHIP_SELECT, teu_pkg::MOD_W'(chip));
      write_reg(teu_pkg::REG_PIXEL_MODULUS, pm);
      write_reg(teu_pkg::REG_TDC_MODULUS, tm);
      write_reg(teu_pkg::REG_CONTROL_MODULUS, cm);
   endtask

   task automatic run_random_phase(input int count);
      repeat (count) send_request(random_request());
      wait_drained();
   endtask

   // Receiver: random stalls, plus one long hold-off when asked for.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = 300;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
   endtask

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin
      hit_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            error_count++;
            $display("%0t: response with nothing expected, actual status %0d epoch %0d",
                     $time, rsp_status, rsp_epoch);
         end else begin
            want = pending_rsp.pop_front();
            checked_count++;
            if (rsp_status !== want.status)
               report_field("status", 64'(want.status), 64'(rsp_status));
            if (rsp_epoch !== want.epoch)
               report_field("epoch", 64'(want.epoch), 64'(rsp_epoch));
            if (rsp_unwrapped_time !== want.unwrapped_time)
               report_field("unwrapped_time", 64'(want.unwrapped_time),
                            64'(rsp_unwrapped_time));
            if (rsp_fine_time !== want.fine_time)
               report_field("fine_time", 64'(want.fine_time),
                            64'(unsigned'(rsp_fine_time)));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Before any anchor: selected-chip hits fall back to epoch zero, others pass.
   task automatic test_no_anchor();
      send_request(build_request(teu_pkg::CMD_PIXEL, 2'd0, '0, 4'hF, 1'b0, '0, '0));
      send_request(build_request(teu_pkg::CMD_PIXEL, 2'd0, '1, 4'h0, 1'b1, '1, '1));
      send_request(build_request(teu_pkg::CMD_TDC, 2'd0, random_time(), 4'h5, 1'b0,
                                 '0, '0));
      send_request(build_request(teu_pkg::CMD_CONTROL, 2'd0, random_time(), 4'h0, 1'b0,
                                 '0, '0));
      send_request(build_request(teu_pkg::CMD_CONTROL, 2'd0, random_time(), 4'h0, 1'b1,
                                 '0, '0));
      send_request(build_request(teu_pkg::CMD_GLOBAL, 2'd3, '1, 4'hF, 1'b1, '0, '0));
      send_request(build_request(teu_pkg::CMD_PIXEL, 2'd2, random_time(), 4'hA, 1'b0,
                                 '1, '0));
      wait_drained();
   endtask

   // Earliest position wins; an equal position keeps the first arrival.
   task automatic test_anchor_choice();
      send_request(build_request(teu_pkg::CMD_GLOBAL, 2'd0, 48'd50_000, 4'h0, 1'b0,
                                 32'h8000_0000, 32'd7));
      send_request(build_request(teu_pkg::CMD_GLOBAL, 2'd0, 48'd99, 4'h0, 1'b0,
                                 32'h8000_0000, 32'd7));
      send_request(build_request(teu_pkg::CMD_GLOBAL, 2'd0, 48'd40_000, 4'h0, 1'b0,
                                 32'h8000_0000, 32'd6));
      send_request(build_request(teu_pkg::CMD_GLOBAL, 2'd0, 48'd1, 4'h0, 1'b0, '1, '1));
      send_request(build_request(teu_pkg::CMD_PIXEL, 2'd0, 48'd1000, 4'h3, 1'b0, '0, '0));
      send_request(build_request(teu_pkg::CMD_TDC, 2'd0, 48'd777, 4'h0, 1'b0, '0, '0));
      wait_drained();
   endtask

   // Modulus extremes, a zero modulus, an exact tie, and a chip switch that
   // keeps the anchor in service.
   task automatic test_epoch_search();
      write_reg(teu_pkg::REG_PIXEL_MODULUS, teu_pkg::MOD_W'(1));
      send_request(build_request(teu_pkg::CMD_PIXEL, 2'd0, '0, 4'h7, 1'b0, '0, '0));
      write_reg(teu_pkg::REG_PIXEL_MODULUS, '1);
      send_request(build_request(teu_pkg::CMD_PIXEL, 2'd0, 48'd12_345, 4'hF, 1'b0,
                                 '0, '0));
      write_reg(teu_pkg::REG_TDC_MODULUS, '0);
      send_request(build_request(teu_pkg::CMD_TDC, 2'd0, 48'd5, 4'h0, 1'b0, '0, '0));
      write_reg(teu_pkg::REG_CONTROL_MODULUS, teu_pkg::MOD_W'(1000));
      // 634500 sits halfway between epochs 5 and 6 around an anchor of 40000
      send_request(build_request(teu_pkg::CMD_CONTROL, 2'd0, 48'd634_500, 4'h0, 1'b0,
                                 '0, '0));
      send_request(build_request(teu_pkg::CMD_CONTROL, 2'd0, 48'd634_500, 4'h0, 1'b1,
                                 '0, '0));
      write_reg(teu_pkg::REG_CHIP_SELECT, teu_pkg::MOD_W'(3));
      send_request(build_request(teu_pkg::CMD_TDC, 2'd3, 48'd9, 4'h0, 1'b0, '0, '0));
      send_request(build_request(teu_pkg::CMD_CONTROL, 2'd3, 48'd640_000, 4'h0, 1'b0,
                                 '0, '0));
      send_request(build_request(teu_pkg::CMD_PIXEL, 2'd0, 48'd42, 4'h1, 1'b0, '0, '0));
      send_request(build_request(teu_pkg::CMD_GLOBAL, 2'd3, 48'd3, 4'h0, 1'b0, '1, 32'd0));
      wait_drained();
   endtask

   // Hold the receiver off while back-to-back requests keep coming, so the
   // core fills up and must stall its request side.
   task automatic test_backpressure();
      hit_req_type r;
      wait_drained();
      steady_flow  = 1'b1;
      hold_request = 1'b1;
      repeat (30) begin
         r      = random_request();
         r.chip = sel_chip + 2'd1;
         send_request(r);
      end
      steady_flow = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_default_moduli();
      apply_settings(2'd0, teu_pkg::PIXEL_MOD_RESET, teu_pkg::TDC_MOD_RESET,
                     teu_pkg::CONTROL_MOD_RESET);
      run_random_phase(140);
   endtask

   task automatic test_random_small_moduli();
      apply_settings(2'd3, random_modulus(16), random_modulus(16), random_modulus(16));
      run_random_phase(140);
   endtask

   task automatic test_random_wide_moduli();
      apply_settings(2'd1, random_modulus(teu_pkg::MOD_W), random_modulus(teu_pkg::MOD_W),
                     random_modulus(teu_pkg::MOD_W));
      run_random_phase(140);
   endtask

   task automatic test_random_extreme_moduli();
      apply_settings(2'd2, '1, '1, teu_pkg::MOD_W'(1));
      run_random_phase(140);
   endtask

   task automatic test_random_back_to_back();
      apply_settings(2'd0, random_modulus(24), random_modulus(teu_pkg::MOD_W),
                     random_modulus(30));
      steady_flow = 1'b1;
      run_random_phase(140);
      steady_flow = 1'b0;
   endtask

   initial begin
      // known values on every input from time zero
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_index           = teu_pkg::REG_CHIP_SELECT;
      csr_wdata           = '0;
      req_valid           = 1'b0;
      req_command         = teu_pkg::CMD_GLOBAL;
      req_chip            = '0;
      req_time_value      = '0;
      req_fine_toa        = '0;
      req_is_packet_count = 1'b0;
      req_chunk_number    = '0;
      req_packet_number   = '0;
      rsp_ready           = 1'b0;
      sel_chip            = '0;
      mod_pixel           = teu_pkg::PIXEL_MOD_RESET;
      mod_tdc             = teu_pkg::TDC_MOD_RESET;
      mod_control         = teu_pkg::CONTROL_MOD_RESET;
      anc_valid           = 1'b0;
      anc_time            = '0;
      anc_chunk           = '0;
      anc_packet          = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_no_anchor();
      test_anchor_choice();
      test_epoch_search();
      test_backpressure();
      test_random_default_moduli();
      test_random_small_moduli();
      test_random_wide_moduli();
      test_random_extreme_moduli();
      test_random_back_to_back();

      wait_drained();
      repeat (110) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses never arrived", $time, pending_rsp.size());
      end
      $display("Run covered %0d requests and %0d checked responses over five settings.",
               sent_count, checked_count);
      $display("Epoch searches against an anchor: %0d; anchor replacements: %0d.",
               searched_count, anchor_moves);
      if (error_count == 0) begin
         $display("tb_timestamp_epoch_unwrapper_core: clean");
      end else begin
         $display("tb_timestamp_epoch_unwrapper_core: errors");
      end
      $finish;
   end

endmodule
